FILE: rtl/core/gld_pkg.sv
// ----------------------------------------------------------------------------
// gld_pkg
// shared types and constants of the gif lzw decoder
// ----------------------------------------------------------------------------
`default_nettype none

package gld_pkg;

  localparam int MAX_CODE_BITS_DEF = 12;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_PUSH  = 2'd1,
    REQ_PULL  = 2'd2,
    REQ_EOD   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STS_PIXEL  = 3'd0,
    STS_NEED   = 3'd1,
    STS_END    = 3'd2,
    STS_ERROR  = 3'd3,
    STS_ACCEPT = 3'd4,
    STS_REJECT = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PULL,
    ST_WALK,
    ST_WALK_RD,
    ST_ADD,
    ST_POP,
    ST_POP_DATA
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/gif_lzw_decoder_unit.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder_unit
// pull-model gif lzw decoder with dictionary and pixel stack in block memories
// ----------------------------------------------------------------------------
// One request enters on the input channel (in_valid / in_stall) and gives
// exactly one response on the output channel (out_valid / out_stall).
// Start, push and no-more-data requests answer in the cycle after acceptance.
// A pull that finds a pending pixel passes ST_PULL, ST_POP and ST_POP_DATA
// (stack memory read). A pull that decodes a code visits ST_PULL per code
// read, clear codes included, plus, for a normal code, ST_WALK and ST_WALK_RD
// per dictionary character walked (prefix/suffix memory read and stack write)
// plus ST_WALK, ST_ADD, ST_POP and ST_POP_DATA for root, table update and pop.
// One request is worked on at a time; the next is taken once the response is
// registered and the output side is not stalled.
// Reset sets the default dictionary for minimum code size 8 with empty bit
// buffer and stack; no memory clearing pass is needed, dictionary entries
// above the fill point read as zero.
// While the receiver stalls, the response is held and no request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_lzw_decoder_unit #(
  parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] data_byte,
  input  wire logic [3:0] min_code_size,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      pixel,
  output logic [2:0]      status
);
  import gld_pkg::*;

  localparam int AW = MAX_CODE_BITS;
  localparam int CW = MAX_CODE_BITS + 1;
  localparam int DEPTH = 1 << MAX_CODE_BITS;
  localparam logic [CW-1:0] TABLE_SIZE = {1'b1, {AW{1'b0}}};

  state_t state, state_next;

  logic [31:0]   bit_buffer, bit_buffer_next;
  logic [5:0]    bit_count, bit_count_next;
  logic [3:0]    code_width, code_width_next;
  logic [CW-1:0] next_free, next_free_next;
  logic [CW-1:0] width_limit, width_limit_next;
  logic [7:0]    first_char, first_char_next;
  logic [AW-1:0] prev_code, prev_code_next;
  logic          fresh, fresh_next;
  logic          exhausted, exhausted_next;
  logic          done, done_next;
  logic [3:0]    min_size, min_size_next;
  logic [CW-1:0] stack_count, stack_count_next;
  logic [AW-1:0] cur, cur_next;
  logic [AW-1:0] incode, incode_next;
  logic          sfx_ok, sfx_ok_next;
  logic          out_valid_next;
  logic [7:0]    pixel_next;
  logic [2:0]    status_next;

  logic [AW-1:0] prefix_mem [DEPTH];
  logic [7:0]    suffix_mem [DEPTH];
  logic [7:0]    stack_mem  [DEPTH];
  logic [AW-1:0] prefix_q;
  logic [7:0]    suffix_q;
  logic [7:0]    stack_q;

  logic          tbl_we;
  logic          stack_we;
  logic [7:0]    stack_wdata;
  logic [CW-1:0] stack_rd;

  logic          accept;
  logic [3:0]    start_ms, dict_ms;
  logic [AW-1:0] clr_code, dict_clear;
  logic [31:0]   code_mask, code_raw;
  logic [AW-1:0] code;
  logic          have_bits, is_clear, is_end, above_clear;
  logic [CW-1:0] nf_inc;
  logic [7:0]    sfx_val;
  logic [AW-1:0] pfx_val;
  logic          stack_full;

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // decode of the buffered code and dictionary init values
  always_comb begin
    if (min_code_size < 4'd2) begin
      start_ms = 4'd2;
    end else if (min_code_size > 4'd8) begin
      start_ms = 4'd8;
    end else begin
      start_ms = min_code_size;
    end
    dict_ms     = (state == ST_IDLE) ? start_ms : min_size;
    clr_code    = {{(AW-1){1'b0}}, 1'b1} << min_size;
    dict_clear  = {{(AW-1){1'b0}}, 1'b1} << dict_ms;
    code_mask   = (32'd1 << code_width) - 32'd1;
    code_raw    = bit_buffer & code_mask;
    code        = code_raw[AW-1:0];
    have_bits   = bit_count >= {2'b00, code_width};
    is_clear    = code == clr_code;
    is_end      = code == clr_code + {{(AW-1){1'b0}}, 1'b1};
    above_clear = code >= clr_code;
    nf_inc      = next_free + {{(CW-1){1'b0}}, 1'b1};
    sfx_val     = sfx_ok ? suffix_q : 8'd0;
    pfx_val     = sfx_ok ? prefix_q : '0;
    stack_full  = stack_count >= TABLE_SIZE;
    stack_rd    = stack_count - {{(CW-1){1'b0}}, 1'b1};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req_t'(req_type) == REQ_PULL) begin
          state_next = ST_PULL;
        end
      end
      ST_PULL: begin
        if (stack_count != '0) begin
          state_next = ST_POP;
        end else if (done || !have_bits) begin
          state_next = ST_IDLE;
        end else if (is_clear) begin
          state_next = ST_PULL;
        end else if (is_end || fresh) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        state_next = (cur >= clr_code) ? ST_WALK_RD : ST_ADD;
      end
      ST_WALK_RD: begin
        state_next = (stack_full || pfx_val == cur) ? ST_IDLE : ST_WALK;
      end
      ST_ADD: begin
        state_next = stack_full ? ST_IDLE : ST_POP;
      end
      ST_POP:      state_next = ST_POP_DATA;
      ST_POP_DATA: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath and response
  always_comb begin
    bit_buffer_next  = bit_buffer;
    bit_count_next   = bit_count;
    code_width_next  = code_width;
    next_free_next   = next_free;
    width_limit_next = width_limit;
    first_char_next  = first_char;
    prev_code_next   = prev_code;
    fresh_next       = fresh;
    exhausted_next   = exhausted;
    done_next        = done;
    min_size_next    = min_size;
    stack_count_next = stack_count;
    cur_next         = cur;
    incode_next      = incode;
    sfx_ok_next      = sfx_ok;
    out_valid_next   = out_valid && out_stall;
    pixel_next       = pixel;
    status_next      = status;
    tbl_we           = 1'b0;
    stack_we         = 1'b0;
    stack_wdata      = first_char;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          out_valid_next = 1'b1;
          pixel_next     = 8'd0;
          status_next    = STS_ACCEPT;
          case (req_t'(req_type))
            REQ_START: begin
              min_size_next    = start_ms;
              code_width_next  = start_ms + 4'd1;
              width_limit_next = {1'b0, dict_clear} << 1;
              next_free_next   = {1'b0, dict_clear} + CW'(2);
              stack_count_next = '0;
              bit_buffer_next  = '0;
              bit_count_next   = '0;
              fresh_next       = 1'b1;
              exhausted_next   = 1'b0;
              done_next        = 1'b0;
            end
            REQ_PUSH: begin
              if (bit_count > 6'd24) begin
                status_next = STS_REJECT;
              end else begin
                bit_buffer_next = bit_buffer | ({24'd0, data_byte} << bit_count);
                bit_count_next  = bit_count + 6'd8;
              end
            end
            REQ_PULL: begin
              out_valid_next = 1'b0;
            end
            default: begin
              exhausted_next = 1'b1;
            end
          endcase
        end
      end
      ST_PULL: begin
        if (stack_count != '0) begin
          // pending pixel, pop follows
        end else if (done) begin
          out_valid_next = 1'b1;
          pixel_next     = 8'd0;
          status_next    = STS_END;
        end else if (!have_bits) begin
          out_valid_next = 1'b1;
          pixel_next     = 8'd0;
          status_next    = exhausted ? STS_ERROR : STS_NEED;
        end else begin
          bit_buffer_next = bit_buffer >> code_width;
          bit_count_next  = bit_count - {2'b00, code_width};
          if (is_clear) begin
            code_width_next  = min_size + 4'd1;
            width_limit_next = {1'b0, dict_clear} << 1;
            next_free_next   = {1'b0, dict_clear} + CW'(2);
            stack_count_next = '0;
            fresh_next       = 1'b1;
          end else if (is_end) begin
            done_next      = 1'b1;
            out_valid_next = 1'b1;
            pixel_next     = 8'd0;
            status_next    = STS_END;
          end else if (fresh) begin
            out_valid_next = 1'b1;
            if (above_clear) begin
              pixel_next  = 8'd0;
              status_next = STS_ERROR;
            end else begin
              fresh_next      = 1'b0;
              first_char_next = code[7:0];
              prev_code_next  = code;
              pixel_next      = code[7:0];
              status_next     = STS_PIXEL;
            end
          end else begin
            incode_next = code;
            if ({1'b0, code} >= next_free) begin
              // kwkwk case
              stack_we         = 1'b1;
              stack_wdata      = first_char;
              stack_count_next = stack_count + CW'(1);
              cur_next         = prev_code;
            end else begin
              cur_next = code;
            end
          end
        end
      end
      ST_WALK: begin
        sfx_ok_next = (cur >= clr_code + AW'(2)) && ({1'b0, cur} < next_free);
      end
      ST_WALK_RD: begin
        if (stack_full) begin
          stack_count_next = '0;
          out_valid_next   = 1'b1;
          pixel_next       = 8'd0;
          status_next      = STS_ERROR;
        end else begin
          stack_we    = 1'b1;
          stack_wdata = sfx_val;
          if (pfx_val == cur) begin
            stack_count_next = '0;
            out_valid_next   = 1'b1;
            pixel_next       = 8'd0;
            status_next      = STS_ERROR;
          end else begin
            stack_count_next = stack_count + CW'(1);
            cur_next         = pfx_val;
          end
        end
      end
      ST_ADD: begin
        first_char_next = cur[7:0];
        if (stack_full) begin
          stack_count_next = '0;
          out_valid_next   = 1'b1;
          pixel_next       = 8'd0;
          status_next      = STS_ERROR;
        end else begin
          stack_we         = 1'b1;
          stack_wdata      = cur[7:0];
          stack_count_next = stack_count + CW'(1);
          if (next_free < TABLE_SIZE) begin
            tbl_we         = 1'b1;
            next_free_next = nf_inc;
            if (nf_inc >= width_limit && width_limit < TABLE_SIZE) begin
              width_limit_next = width_limit << 1;
              code_width_next  = code_width + 4'd1;
            end
          end
          prev_code_next = incode;
        end
      end
      ST_POP: begin
        stack_count_next = stack_rd;
      end
      ST_POP_DATA: begin
        out_valid_next = 1'b1;
        pixel_next     = stack_q;
        status_next    = STS_PIXEL;
      end
      default: begin
      end
    endcase
  end

  // dictionary and stack memories
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      prefix_mem[next_free[AW-1:0]] <= prev_code;
      suffix_mem[next_free[AW-1:0]] <= cur[7:0];
    end
    prefix_q <= prefix_mem[cur];
    suffix_q <= suffix_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_count[AW-1:0]] <= stack_wdata;
    end
    stack_q <= stack_mem[stack_rd[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      bit_buffer  <= '0;
      bit_count   <= '0;
      code_width  <= 4'd9;
      next_free   <= CW'(258);
      width_limit <= CW'(512);
      first_char  <= '0;
      prev_code   <= '0;
      fresh       <= 1'b0;
      exhausted   <= 1'b0;
      done        <= 1'b0;
      min_size    <= 4'd8;
      stack_count <= '0;
      cur         <= '0;
      incode      <= '0;
      sfx_ok      <= 1'b0;
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      bit_buffer  <= bit_buffer_next;
      bit_count   <= bit_count_next;
      code_width  <= code_width_next;
      next_free   <= next_free_next;
      width_limit <= width_limit_next;
      first_char  <= first_char_next;
      prev_code   <= prev_code_next;
      fresh       <= fresh_next;
      exhausted   <= exhausted_next;
      done        <= done_next;
      min_size    <= min_size_next;
      stack_count <= stack_count_next;
      cur         <= cur_next;
      incode      <= incode_next;
      sfx_ok      <= sfx_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    pixel  <= pixel_next;
    status <= status_next;
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= TABLE_SIZE)
    else $error("stack count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_POP |-> stack_count != '0)
    else $error("pop of empty stack");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    state == ST_POP |=> state == ST_POP_DATA && out_valid == 1'b0)
    else $error("pop not followed by data");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall)
    else $error("request taken while busy");

endmodule

`default_nettype wire

FILE: verif/gif_lzw_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder_unit_tb
// drives start, push, pull and end-of-data requests into the gif lzw decoder
// and compares every response against a behavioral lzw decoder kept in step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gif_lzw_decoder_unit_tb;
  import gld_pkg::*;

  localparam int DICT_SIZE = 4096;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    req_t       kind;
    logic [7:0] data;
    logic [3:0] mcs;
  } request_t;

  typedef struct packed {
    logic [7:0] pix;
    status_t    sts;
  } response_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic [3:0] min_code_size;
  logic out_valid;
  logic out_stall;
  logic [7:0] pixel;
  logic [2:0] status;

  gif_lzw_decoder_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .data_byte(data_byte), .min_code_size(min_code_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel(pixel), .status(status)
  );

  // decoder state
  logic [11:0] dec_prefix [DICT_SIZE];
  logic [7:0]  dec_suffix [DICT_SIZE];
  logic [7:0]  dec_stack [DICT_SIZE];
  int unsigned dec_depth;
  logic [31:0] dec_bits;
  int unsigned dec_nbits;
  int unsigned dec_width;
  int unsigned dec_next;
  int unsigned dec_limit;
  logic [7:0]  dec_first;
  int unsigned dec_prev;
  bit dec_fresh, dec_exhausted, dec_done;
  int unsigned dec_min;

  request_t  pending_requests [$];
  response_t expected_responses [$];
  int errors;
  int cycles;
  bit stimulus_done;
  int send_wait;
  int recv_wait;

  task automatic dict_reset();
    int unsigned clr;
    clr = 1 << dec_min;
    for (int i = 0; i < DICT_SIZE; i++) begin
      dec_prefix[i] = '0;
      dec_suffix[i] = (i < clr) ? i[7:0] : 8'd0;
    end
    dec_width = dec_min + 1;
    dec_limit = 2 * clr;
    dec_next = clr + 2;
    dec_depth = 0;
  endtask

  function automatic bit stack_push(logic [7:0] v);
    if (dec_depth >= DICT_SIZE) return 0;
    dec_stack[dec_depth] = v;
    dec_depth++;
    return 1;
  endfunction

  task automatic decode_pull(output status_t sts, output logic [7:0] pix);
    int unsigned clr, code, incode;
    clr = 1 << dec_min;
    pix = 8'd0;
    forever begin
      if (dec_depth > 0) begin
        dec_depth--;
        pix = dec_stack[dec_depth];
        sts = STS_PIXEL;
        return;
      end
      if (dec_done) begin
        sts = STS_END;
        return;
      end
      if (dec_nbits < dec_width) begin
        sts = dec_exhausted ? STS_ERROR : STS_NEED;
        return;
      end
      code = dec_bits & ((32'd1 << dec_width) - 1);
      dec_bits = dec_bits >> dec_width;
      dec_nbits -= dec_width;
      code &= DICT_SIZE - 1;
      if (code == clr) begin
        dict_reset();
        dec_fresh = 1;
        continue;
      end
      if (code == clr + 1) begin
        dec_done = 1;
        sts = STS_END;
        return;
      end
      if (dec_fresh) begin
        if (code >= clr) begin
          sts = STS_ERROR;
          return;
        end
        dec_fresh = 0;
        dec_first = code[7:0];
        dec_prev = code;
        pix = code[7:0];
        sts = STS_PIXEL;
        return;
      end
      incode = code;
      if (code >= dec_next) begin
        void'(stack_push(dec_first));
        code = dec_prev & (DICT_SIZE - 1);
      end
      while (code >= clr) begin
        if (!stack_push(dec_suffix[code]) || dec_prefix[code] == code) begin
          dec_depth = 0;
          sts = STS_ERROR;
          return;
        end
        code = dec_prefix[code];
      end
      dec_first = dec_suffix[code];
      if (!stack_push(dec_first)) begin
        dec_depth = 0;
        sts = STS_ERROR;
        return;
      end
      if (dec_next < DICT_SIZE) begin
        dec_prefix[dec_next] = dec_prev[11:0];
        dec_suffix[dec_next] = dec_first;
        dec_next++;
        if (dec_next >= dec_limit && dec_limit < DICT_SIZE) begin
          dec_limit *= 2;
          dec_width++;
        end
      end
      dec_prev = incode;
    end
  endtask

  task automatic predict_response(request_t r);
    response_t e;
    int unsigned m;
    e.pix = 8'd0;
    e.sts = STS_ACCEPT;
    case (r.kind)
      REQ_START: begin
        m = r.mcs;
        if (m < 2) m = 2;
        if (m > 8) m = 8;
        dec_min = m;
        dict_reset();
        dec_bits = '0;
        dec_nbits = 0;
        dec_fresh = 1;
        dec_exhausted = 0;
        dec_done = 0;
      end
      REQ_PUSH: begin
        if (dec_nbits > 24) begin
          e.sts = STS_REJECT;
        end else begin
          dec_bits = dec_bits | (32'(r.data) << dec_nbits);
          dec_nbits += 8;
        end
      end
      REQ_PULL: decode_pull(e.sts, e.pix);
      default: dec_exhausted = 1;
    endcase
    expected_responses.push_back(e);
  endtask

  // stimulus builders
  task automatic add_req(req_t k, logic [7:0] d, logic [3:0] m);
    request_t r;
    r.kind = k;
    r.data = d;
    r.mcs = m;
    pending_requests.push_back(r);
  endtask

  // packs codes lsb first and interleaves pushes with pulls
  task automatic add_stream(int unsigned msz, int ncodes, bit wellformed);
    int unsigned w, nxt, lim, clr, code, acc_bits;
    logic [63:0] acc;
    clr = 1 << msz;
    w = msz + 1;
    nxt = clr + 2;
    lim = 2 * clr;
    acc = '0;
    acc_bits = 0;
    add_req(REQ_START, 8'($urandom), 4'(msz));
    for (int i = 0; i < ncodes; i++) begin
      if (!wellformed) code = $urandom_range((1 << w) - 1, 0);
      else if (i == 0 || $urandom_range(40, 0) == 0) code = (i == 0) ? clr : clr;
      else if (i == 1 || $urandom_range(1, 0) == 0) code = $urandom_range(clr - 1, 0);
      else code = $urandom_range(nxt, clr + 2);
      if (i == ncodes - 1 && wellformed) code = clr + 1;
      acc = acc | (64'(code) << acc_bits);
      acc_bits += w;
      if (wellformed) begin
        if (code == clr) begin
          w = msz + 1;
          nxt = clr + 2;
          lim = 2 * clr;
        end else if (i > 1 && nxt < DICT_SIZE) begin
          nxt++;
          if (nxt >= lim && lim < DICT_SIZE) begin
            lim *= 2;
            w++;
          end
        end
      end
      while (acc_bits >= 8) begin
        add_req(REQ_PUSH, acc[7:0], 4'($urandom));
        acc = acc >> 8;
        acc_bits -= 8;
      end
      repeat ($urandom_range(4, 1)) add_req(REQ_PULL, 8'($urandom), 4'($urandom));
    end
    if (acc_bits > 0) add_req(REQ_PUSH, acc[7:0], 4'($urandom));
    if ($urandom_range(1, 0)) add_req(REQ_EOD, 8'($urandom), 4'($urandom));
    repeat ($urandom_range(6, 2)) add_req(REQ_PULL, 8'($urandom), 4'($urandom));
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1;
    in_valid = 0;
    req_type = '0;
    data_byte = '0;
    min_code_size = '0;
    out_stall = 0;
    errors = 0;
    stimulus_done = 0;
    dec_min = 8;
    dict_reset();
    dec_bits = '0;
    dec_nbits = 0;
    dec_first = '0;
    dec_prev = 0;
    dec_fresh = 0;
    dec_exhausted = 0;
    dec_done = 0;
    // directed: pull before start, full buffer, min size extremes, error cases
    add_req(REQ_PULL, 8'h00, 4'h0);
    add_req(REQ_PUSH, 8'hff, 4'hf);
    repeat (4) add_req(REQ_PUSH, 8'h00, 4'h0);
    add_req(REQ_PULL, 8'h00, 4'h0);
    add_req(REQ_START, 8'h00, 4'd1);
    add_req(REQ_PUSH, 8'b0011_1111, 4'h0);
    add_req(REQ_PULL, 8'h00, 4'h0);
    add_req(REQ_PULL, 8'h00, 4'h0);
    add_req(REQ_START, 8'h00, 4'd15);
    add_req(REQ_PUSH, 8'h05, 4'h0);
    add_req(REQ_PULL, 8'h00, 4'h0);
    add_req(REQ_EOD, 8'h00, 4'h0);
    add_req(REQ_PULL, 8'h00, 4'h0);
    add_req(REQ_START, 8'h00, 4'd2);
    add_req(REQ_PUSH, 8'b0111_1110, 4'h0);
    add_req(REQ_PULL, 8'h00, 4'h0);
    add_req(REQ_PULL, 8'h00, 4'h0);
    add_req(REQ_PULL, 8'h00, 4'h0);
    add_stream(2, 12, 1'b1);
    while (pending_requests.size() < 1900) begin
      case ($urandom_range(9, 0))
        0: add_stream($urandom_range(8, 2), $urandom_range(12, 2), 1'b0);
        1: add_req(req_t'($urandom_range(3, 0)), 8'($urandom), 4'($urandom));
        2: add_stream(8, $urandom_range(40, 10), 1'b1);
        default: add_stream($urandom_range(5, 2), $urandom_range(40, 4), 1'b1);
      endcase
    end
    repeat (2) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
        $display("gif_lzw_decoder_unit_tb: FAIL");
        $finish;
      end
    end else begin
      cycles <= 0;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_response(pending_requests.pop_front());
        send_wait = $urandom_range(3, 0) == 0 ? $urandom_range(6, 0) : 0;
      end
      if (in_valid && in_stall) begin
        // hold
      end else if (send_wait > 0) begin
        send_wait--;
        in_valid <= 0;
      end else if (pending_requests.size() > 0) begin
        in_valid <= 1;
        req_type <= pending_requests[0].kind;
        data_byte <= pending_requests[0].data;
        min_code_size <= pending_requests[0].mcs;
      end else begin
        in_valid <= 0;
        stimulus_done <= 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    response_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          $display("%0t unexpected response pixel %0d status %0d", $time, pixel, status);
          errors++;
        end else begin
          e = expected_responses.pop_front();
          if (e.pix !== pixel || e.sts !== status) begin
            $display("%0t mismatch expected pixel %0d status %0d actual pixel %0d status %0d",
                     $time, e.pix, e.sts, pixel, status);
            errors++;
          end
        end
        recv_wait = $urandom_range(3, 0) == 0 ? $urandom_range(6, 0) : 0;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  initial begin
    send_wait = 0;
    recv_wait = 0;
    @(negedge rst);
    wait (stimulus_done && expected_responses.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_responses.size() == 0) begin
      $display("gif_lzw_decoder_unit_tb: PASS");
    end else begin
      $display("gif_lzw_decoder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: gif_lzw_decoder_unit.f
rtl/core/gld_pkg.sv
rtl/core/gif_lzw_decoder_unit.sv
verif/gif_lzw_decoder_unit_tb.sv
